// ===== hdl/zero_run_length_encoder_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the zero run length encoder
// Shared concurrent assertion forms, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ZERO_RUN_LENGTH_ENCODER_TOP_ASSERT_SVH
`define ZERO_RUN_LENGTH_ENCODER_TOP_ASSERT_SVH

// Same-cycle implication.
`define ZRLE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("zrle assertion failed");

// Next-cycle implication.
`define ZRLE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("zrle assertion failed");

`endif

// ===== hdl/zrle_pkg.sv =====
// ----------------------------------------------------------------------------
// zrle_pkg
// Token type and fixed constants of the zero run length encoder.
// ----------------------------------------------------------------------------
package zrle_pkg;

  localparam int BYTE_W = 8;

  // Token kinds
  localparam logic KIND_RUN     = 1'b0;
  localparam logic KIND_LITERAL = 1'b1;

  typedef struct packed {
    logic              is_literal;
    logic [BYTE_W-1:0] value;
  } token_t;

endpackage

// ===== hdl/zrle_encode.sv =====
// ----------------------------------------------------------------------------
// zrle_encode
// Input register, run counter and pending byte buffer; builds one token burst
// per accepted item.
// ----------------------------------------------------------------------------
module zrle_encode #(
  parameter int              RUN_BITS = 8,
  parameter longint unsigned MAX_RUN  = 255,
  parameter int              PEND_DEPTH = RUN_BITS / 8,
  parameter int              IW = $clog2(PEND_DEPTH + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           diff_i,
  input  logic [7:0]           orig_i,
  input  logic                 end_i,
  input  logic                 load_ok_i,
  output logic                 load_o,
  output zrle_pkg::token_t     tok_o [PEND_DEPTH+1],
  output logic [IW-1:0]        last_idx_o
);
  import zrle_pkg::*;

  localparam int CNT_W   = $clog2(MAX_RUN + 64'd1);
  localparam int NW      = $clog2(PEND_DEPTH + 2);
  localparam int RUN_MIN = PEND_DEPTH + 1;

  logic              vld_q;
  logic [7:0]        diff_q, orig_q;
  logic              end_q;
  logic [CNT_W-1:0]  cnt_q, cnt_d, cnt_inc;
  logic [BYTE_W-1:0] pend_q [PEND_DEPTH];
  logic [BYTE_W-1:0] pend_v [PEND_DEPTH];
  logic              d_zero, has_run, has_tail, empty, take;
  logic [CNT_W-1:0]  run_val;
  logic [IW-1:0]     lit_cnt;
  logic [NW-1:0]     tok_cnt;
  token_t            run_tok, tail_tok;

  assign d_zero  = (diff_q == 8'd0);
  assign cnt_inc = cnt_q + CNT_W'(1);

  always_comb begin
    for (int i = 0; i < PEND_DEPTH; i++) begin
      pend_v[i] = (d_zero && cnt_q == CNT_W'(i)) ? orig_q : pend_q[i];
    end
    has_run  = 1'b0;
    has_tail = 1'b0;
    run_val  = cnt_q;
    lit_cnt  = '0;
    cnt_d    = cnt_q;
    if (d_zero) begin
      cnt_d = cnt_inc;
      if (cnt_inc == CNT_W'(MAX_RUN)) begin
        // Cap reached: emit the run at once.
        has_run = 1'b1;
        run_val = cnt_inc;
        cnt_d   = '0;
      end else if (end_q) begin
        cnt_d = '0;
        if (cnt_inc >= CNT_W'(RUN_MIN)) begin
          has_run = 1'b1;
          run_val = cnt_inc;
        end else begin
          lit_cnt = IW'(cnt_inc);
        end
      end
    end else begin
      has_tail = 1'b1;
      cnt_d    = '0;
      if (cnt_q >= CNT_W'(RUN_MIN)) begin
        has_run = 1'b1;
      end else begin
        lit_cnt = IW'(cnt_q);
      end
    end
  end

  assign run_tok  = '{is_literal: KIND_RUN, value: run_val[BYTE_W-1:0]};
  assign tail_tok = '{is_literal: KIND_LITERAL, value: orig_q};

  always_comb begin
    for (int i = 0; i < PEND_DEPTH; i++) begin
      tok_o[i] = (IW'(i) < lit_cnt) ? '{is_literal: KIND_LITERAL, value: pend_v[i]}
                                    : tail_tok;
    end
    tok_o[PEND_DEPTH] = tail_tok;
    if (has_run) begin
      tok_o[0] = run_tok;
      tok_o[1] = tail_tok;
    end
  end

  assign tok_cnt    = NW'(lit_cnt) + NW'(has_run) + NW'(has_tail);
  assign last_idx_o = IW'(tok_cnt - NW'(1));
  assign empty      = (tok_cnt == '0);
  assign take       = vld_q && (empty || load_ok_i);
  assign load_o     = take && !empty;
  assign in_ready_o = !vld_q || take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (in_ready_o) begin
        vld_q <= in_valid_i;
      end
      if (take) begin
        cnt_q <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      diff_q <= diff_i;
      orig_q <= orig_i;
      end_q  <= end_i;
    end
    if (take) begin
      pend_q <= pend_v;
    end
  end

  `include "zero_run_length_encoder_top_assert.svh"

  `ZRLE_ASSERT_NOW(a_cnt_below_cap, 1'b1, cnt_q != CNT_W'(MAX_RUN))
  `ZRLE_ASSERT_NEXT(a_nonzero_clears_run, take && !d_zero, cnt_q == '0)
  `ZRLE_ASSERT_NEXT(a_end_clears_run, take && end_q, cnt_q == '0)

endmodule

// ===== hdl/zrle_emit.sv =====
// ----------------------------------------------------------------------------
// zrle_emit
// Burst register and output sequencer: hands out one token per transfer.
// ----------------------------------------------------------------------------
module zrle_emit #(
  parameter int PEND_DEPTH = 1,
  parameter int IW = $clog2(PEND_DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  zrle_pkg::token_t tok_i [PEND_DEPTH+1],
  input  logic [IW-1:0]    last_idx_i,
  output logic             load_ok_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output zrle_pkg::token_t out_tok_o,
  output logic             out_last_o
);
  import zrle_pkg::*;

  logic          busy_q;
  logic [IW-1:0] pos_q, last_q;
  token_t        tok_q [PEND_DEPTH+1];
  logic          tok_last;

  assign tok_last    = (pos_q == last_q);
  assign load_ok_o   = !busy_q || (out_ready_i && tok_last);
  assign out_valid_o = busy_q;
  assign out_tok_o   = tok_q[pos_q];
  assign out_last_o  = tok_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pos_q  <= '0;
      last_q <= '0;
    end else if (load_i) begin
      busy_q <= 1'b1;
      pos_q  <= '0;
      last_q <= last_idx_i;
    end else if (busy_q && out_ready_i) begin
      // Advance through the burst; drop busy after its last token.
      if (tok_last) begin
        busy_q <= 1'b0;
      end else begin
        pos_q <= pos_q + IW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      tok_q <= tok_i;
    end
  end

  `include "zero_run_length_encoder_top_assert.svh"

  `ZRLE_ASSERT_NOW(a_pos_in_burst, busy_q, pos_q <= last_q)
  `ZRLE_ASSERT_NOW(a_load_when_free, load_i, load_ok_o)
  `ZRLE_ASSERT_NEXT(a_stall_holds, busy_q && !out_ready_i, busy_q && $stable(pos_q))

endmodule

// ===== hdl/zero_run_length_encoder_top.sv =====
// ----------------------------------------------------------------------------
// zero_run_length_encoder_top
// Zero run length encoder: byte stream in, run and literal tokens out.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: tdata = {orig_byte, diff_byte}, tlast = stream_end.
//   Master stream: tdata = token_value, tuser = is_literal (0 run, 1 literal),
//   tlast = last_of_burst (last token caused by one input item).
//   Zero diff bytes build a run. A run of at least RUN_BITS/8+1 positions comes
//   out as one run token; shorter runs come out as literals of the buffered
//   original bytes. A run is cut at MAX_RUN, and tlast on input flushes it.
//   An item is registered on input; its burst is then loaded from the input
//   register into the burst register, which drives its first token.
//   Throughput: one item per cycle while each item yields at most one token
//   and master tready stays high; an item that yields more tokens holds the
//   burst register until its last token is taken.
//   Items yielding no token leave the input register without a burst load.
//   Reset clears the run counter and both valid stages; buffered bytes need
//   no clearing. When master tready is low the current token holds, the next
//   burst waits in the input register, and s_axis_tready drops behind it.
// ----------------------------------------------------------------------------
module zero_run_length_encoder_top #(
  parameter int              RUN_BITS = 8,
  parameter longint unsigned MAX_RUN  = 255
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Slave stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [7:0] diff_byte, [15:8] orig_byte
  input  logic        s_axis_tlast_i,   // stream_end
  // Master stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [7:0] token_value
  output logic        m_axis_tuser_o,   // [0] is_literal
  output logic        m_axis_tlast_o    // last_of_burst
);
  import zrle_pkg::*;

  // Bytes buffered for a short run; a burst is at most this plus one token.
  localparam int PEND_DEPTH = RUN_BITS / 8;
  localparam int IW         = $clog2(PEND_DEPTH + 1);

  logic          load, load_ok;
  token_t        burst_tok [PEND_DEPTH+1];
  logic [IW-1:0] burst_last;
  token_t        out_tok;

  // Count runs and build each item's burst of tokens.
  zrle_encode #(
    .RUN_BITS   (RUN_BITS),
    .MAX_RUN    (MAX_RUN),
    .PEND_DEPTH (PEND_DEPTH),
    .IW         (IW)
  ) u_encode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .diff_i     (s_axis_tdata_i[7:0]),
    .orig_i     (s_axis_tdata_i[15:8]),
    .end_i      (s_axis_tlast_i),
    .load_ok_i  (load_ok),
    .load_o     (load),
    .tok_o      (burst_tok),
    .last_idx_o (burst_last)
  );

  // Hand out the burst one transfer at a time.
  zrle_emit #(
    .PEND_DEPTH (PEND_DEPTH),
    .IW         (IW)
  ) u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .tok_i       (burst_tok),
    .last_idx_i  (burst_last),
    .load_ok_o   (load_ok),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_tok_o   (out_tok),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = out_tok.value;
  assign m_axis_tuser_o = out_tok.is_literal;

endmodule

// ===== test/tb_zero_run_length_encoder_top.sv =====
// ----------------------------------------------------------------------------
// tb_zero_run_length_encoder_top
// Self-checking bench for the zero run length encoder. Byte items go in on
// the slave stream, a local token predictor mirrors the run counter and the
// buffered original byte, and every token transfer on the master stream is
// matched field by field against the oldest predicted token.
// ----------------------------------------------------------------------------
module tb_zero_run_length_encoder_top;
  timeunit 1ns;
  timeprecision 1ps;

  import zrle_pkg::*;

  localparam int          CLK_PERIOD   = 4;
  localparam int          RUN_BITS     = 8;
  localparam int unsigned MAX_RUN      = 255;
  localparam int unsigned RUN_MIN      = RUN_BITS / 8 + 1;
  localparam int unsigned PEND_DEPTH   = RUN_BITS / 8;
  localparam int unsigned IDLE_PCT     = 9;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  // One predicted token with the end-of-burst flag it must carry.
  typedef struct packed {
    token_t tok;
    logic   last;
  } burst_token_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_valid;
  logic [15:0] s_data;   // [7:0] diff_byte, [15:8] orig_byte
  logic        s_last;   // stream_end
  logic        m_ready;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [7:0]  m_axis_tdata_o;   // [7:0] token_value
  logic        m_axis_tuser_o;   // [0] is_literal
  logic        m_axis_tlast_o;   // last_of_burst

  // Predictor state: length of the open zero run and its buffered originals.
  int unsigned  zero_run_len;
  logic [7:0]   run_head_bytes [PEND_DEPTH];
  token_t       burst_tokens [$];
  burst_token_t pending_tokens [$];

  bit          src_idle_en;
  bit          sink_idle_en;
  int unsigned mismatch_cnt;
  int unsigned cycle_cnt;

  zero_run_length_encoder_top #(
    .RUN_BITS(RUN_BITS),
    .MAX_RUN (MAX_RUN)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_data),
    .s_axis_tlast_i (s_last),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always begin
    #(CLK_PERIOD / 2) clk_i = 1'b1;
    #(CLK_PERIOD / 2) clk_i = 1'b0;
  end

  // Stop a hung run well past the slowest legal finish.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Sink side: drop tready in a few cycles of a hundred while idling is on.
  always @(negedge clk_i) begin
    m_ready <= (sink_idle_en && $urandom_range(99) < IDLE_PCT) ? 1'b0 : 1'b1;
  end

  task automatic report_mismatch(input string msg);
    mismatch_cnt++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // Close the open run: one run token when long enough, else one literal per
  // buffered position.
  function automatic void flush_zero_run();
    token_t tok;
    if (zero_run_len == 0) return;
    if (zero_run_len >= RUN_MIN) begin
      tok.is_literal = KIND_RUN;
      tok.value      = 8'(zero_run_len);
      burst_tokens.push_back(tok);
    end else begin
      for (int unsigned j = 0; j < zero_run_len; j++) begin
        tok.is_literal = KIND_LITERAL;
        tok.value      = (j < PEND_DEPTH) ? run_head_bytes[j] : 8'h00;
        burst_tokens.push_back(tok);
      end
    end
    zero_run_len = 0;
  endfunction

  // Work out the tokens one accepted item causes and queue them in order.
  function automatic void predict_tokens(input logic [7:0] diff, input logic [7:0] orig,
                                         input logic ends);
    token_t       tok;
    burst_token_t bt;
    burst_tokens.delete();
    if (diff == 8'h00) begin
      if (zero_run_len < PEND_DEPTH) run_head_bytes[zero_run_len] = orig;
      zero_run_len++;
      // Emit a capped run at once; the next zero opens a fresh run.
      if (zero_run_len >= MAX_RUN) flush_zero_run();
    end else begin
      flush_zero_run();
      tok.is_literal = KIND_LITERAL;
      tok.value      = orig;
      burst_tokens.push_back(tok);
    end
    if (ends) flush_zero_run();
    foreach (burst_tokens[i]) begin
      bt.tok  = burst_tokens[i];
      bt.last = (i == burst_tokens.size() - 1);
      pending_tokens.push_back(bt);
    end
  endfunction

  // Present one item at a falling edge and hold it until the transfer.
  task automatic send_item(input logic [7:0] diff, input logic [7:0] orig,
                           input logic ends);
    while (src_idle_en && $urandom_range(99) < IDLE_PCT) begin
      @(negedge clk_i);
      s_valid <= 1'b0;
    end
    @(negedge clk_i);
    s_valid <= 1'b1;
    s_data  <= {orig, diff};
    s_last  <= ends;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    predict_tokens(diff, orig, ends);
  endtask

  // Drop tvalid and hold off until every predicted token has come out.
  task automatic wait_drained();
    @(negedge clk_i);
    s_valid <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk_i);
  endtask

  // Check every token transfer against the oldest prediction.
  always @(posedge clk_i) begin
    burst_token_t exp_tok;
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      if (pending_tokens.size() == 0) begin
        report_mismatch($sformatf("unexpected token kind=%0b value=%02h last=%0b",
                                  m_axis_tuser_o, m_axis_tdata_o, m_axis_tlast_o));
      end else begin
        exp_tok = pending_tokens.pop_front();
        if (m_axis_tuser_o !== exp_tok.tok.is_literal)
          report_mismatch($sformatf("is_literal %0b, want %0b",
                                    m_axis_tuser_o, exp_tok.tok.is_literal));
        if (m_axis_tdata_o !== exp_tok.tok.value)
          report_mismatch($sformatf("token_value %02h, want %02h",
                                    m_axis_tdata_o, exp_tok.tok.value));
        if (m_axis_tlast_o !== exp_tok.last)
          report_mismatch($sformatf("last_of_burst %0b, want %0b",
                                    m_axis_tlast_o, exp_tok.last));
      end
    end
  end

  // Nonzero diff bytes only: field extremes and alternating bit patterns.
  task automatic test_literal_extremes();
    send_item(8'hFF, 8'h00, 1'b0);
    send_item(8'h01, 8'hFF, 1'b0);
    send_item(8'h80, 8'hA5, 1'b0);
    send_item(8'h7F, 8'h5A, 1'b0);
    send_item(8'hAA, 8'h55, 1'b0);
    send_item(8'h55, 8'hAA, 1'b1);
  endtask

  // Runs below the minimum length come back as literals of the originals.
  task automatic test_short_runs();
    send_item(8'h00, 8'h3C, 1'b0);
    send_item(8'h12, 8'hC3, 1'b0);   // ended by a nonzero byte
    send_item(8'h00, 8'hFF, 1'b1);   // ended by the stream end on the zero
    send_item(8'h00, 8'h81, 1'b0);
    send_item(8'hFE, 8'h7E, 1'b1);   // flush, literal, then nothing left
  endtask

  // Runs at or above the minimum length collapse into one run token.
  task automatic test_run_tokens();
    send_item(8'h00, 8'h11, 1'b0);
    send_item(8'h00, 8'h22, 1'b0);
    send_item(8'h9C, 8'h33, 1'b0);
    send_item(8'h00, 8'h44, 1'b0);
    send_item(8'h00, 8'h55, 1'b0);
    send_item(8'h00, 8'h66, 1'b1);
    send_item(8'h00, 8'h77, 1'b0);
    send_item(8'h00, 8'h88, 1'b0);
    send_item(8'h01, 8'h99, 1'b1);
  endtask

  // Cap the run at MAX_RUN without a stream end, then open a fresh run.
  task automatic test_run_cap();
    for (int unsigned i = 0; i < MAX_RUN; i++) send_item(8'h00, 8'($urandom), 1'b0);
    // The run after the cap buffers a fresh original byte.
    send_item(8'h00, 8'hC7, 1'b0);
    send_item(8'h40, 8'h2D, 1'b0);
  endtask

  // Mostly well-formed segments: a zero run of random length, then a nonzero
  // byte, sometimes closing the stream. The rest is unshaped noise.
  task automatic test_random_streams(input int unsigned n_items);
    int unsigned done;
    int unsigned zeros;
    int unsigned pick;
    bit          ends_seg;
    bit          end_on_zero;
    done = 0;
    while (done < n_items) begin
      if ($urandom_range(99) < 85) begin
        pick  = $urandom_range(99);
        zeros = (pick < 30) ? 0 :
                (pick < 55) ? 1 :
                (pick < 90) ? $urandom_range(6, 2) : $urandom_range(40, 7);
        ends_seg    = ($urandom_range(99) < 12);
        end_on_zero = ends_seg && (zeros > 0) && ($urandom_range(1) == 1);
        for (int unsigned i = 0; i < zeros; i++)
          send_item(8'h00, 8'($urandom), end_on_zero && (i == zeros - 1));
        if (!end_on_zero) send_item(8'($urandom_range(255, 1)), 8'($urandom), ends_seg);
        done += zeros + (end_on_zero ? 0 : 1);
      end else begin
        send_item(($urandom_range(1) == 1) ? 8'h00 : 8'($urandom), 8'($urandom),
                  $urandom_range(1) == 1);
        done++;
      end
    end
  endtask

  // Hold the sender mid-stream until the block has emptied, then resume the
  // same open run.
  task automatic test_drain_pause();
    send_item(8'h5A, 8'h01, 1'b0);
    send_item(8'h00, 8'hE4, 1'b0);
    send_item(8'hA5, 8'h1B, 1'b0);
    wait_drained();
    send_item(8'h00, 8'h6F, 1'b0);
    wait_drained();
    send_item(8'h00, 8'h90, 1'b0);
    send_item(8'h00, 8'h09, 1'b1);
  endtask

  initial begin
    rst_ni       = 1'b0;
    s_valid      = 1'b0;
    s_data       = '0;
    s_last       = 1'b0;
    m_ready      = 1'b0;
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    mismatch_cnt = 0;
    cycle_cnt    = 0;
    zero_run_len = 0;

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_literal_extremes();
    test_short_runs();
    test_run_tokens();
    test_run_cap();
    test_random_streams(50);
    test_drain_pause();
    // Long stretch at full rate on both sides.
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    test_random_streams(45);
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    test_random_streams(50);

    // Drain, then give stray tokens time to show up.
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
